@@ rtl/core/fifo_rbv_pkg.sv @@
// ----------------------------------------------------------------------------
// fifo_rbv_pkg - shared types and constants for the queue with remove-by-value
// Sizes, operation and status codes, controller states and the command and
// status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package fifo_rbv_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_count;

    typedef enum logic [1:0] {
        FN_PUSH   = 2'd0,
        FN_POP    = 2'd1,
        FN_REMOVE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_DATA,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic    load_in;    // capture the incoming word, clear index
        logic    mem_rd;     // read slot(index + rd_next)
        logic    rd_next;
        logic    wr_push;    // write the item value at the tail
        logic    wr_shift;   // write the read data at slot(index)
        logic    idx_inc;
        logic    head_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_popped;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  match;
        logic  idx_zero;
        logic  idx_last;
        logic  out_busy;
    } t_dp_stat;

    // Circular slot: head plus offset, wrapped at DEPTH.
    function automatic t_addr slot_of(t_addr head, t_addr offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/core/fifo_rbv_ctrl.sv @@
// ----------------------------------------------------------------------------
// fifo_rbv_ctrl - operation sequencer
// Walks each item through decode, memory reads, scan, close-up and response.
// ----------------------------------------------------------------------------
module fifo_rbv_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  fifo_rbv_pkg::t_dp_stat i_stat,
    output fifo_rbv_pkg::t_dp_cmd  o_cmd
);
    import fifo_rbv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (i_stat.func)
                    FN_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.wr_push = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    FN_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_POP_DATA;
                        end
                    end
                    FN_REMOVE: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOT_FOUND;
                        end else begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_SCAN_CMP;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_POP_DATA: begin
                o_cmd.set_popped = 1'b1;
                o_cmd.head_inc   = 1'b1;
                o_cmd.cnt_dec    = 1'b1;
                n_state          = S_RESP;
            end
            S_SCAN_CMP: begin
                if (i_stat.match) begin
                    if (i_stat.idx_zero) begin
                        // head word: just move the head
                        o_cmd.head_inc = 1'b1;
                        o_cmd.cnt_dec  = 1'b1;
                        n_state        = S_RESP;
                    end else if (i_stat.idx_last) begin
                        // tail word: pull the tail back
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = S_RESP;
                    end else begin
                        o_cmd.mem_rd  = 1'b1;
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_SHIFT_WR;
                    end
                end else if (i_stat.idx_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_FOUND;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.mem_rd  = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.mem_rd  = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SHIFT_WR;
                end
            end
            S_RESP: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/fifo_rbv_dp.sv @@
// ----------------------------------------------------------------------------
// fifo_rbv_dp - queue storage, pointers and result register
// Word memory with registered read, head/count/index registers, match
// compare and the output register toward the master side.
// ----------------------------------------------------------------------------
module fifo_rbv_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_func,
    input  logic [31:0]            i_value,
    input  fifo_rbv_pkg::t_dp_cmd  i_cmd,
    output fifo_rbv_pkg::t_dp_stat o_stat,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [31:0]            o_popped,
    output logic [1:0]             o_status,
    output logic [4:0]             o_occupancy
);
    import fifo_rbv_pkg::*;

    t_word   mem [DEPTH];
    t_word   r_rd_data;
    t_func   r_func;
    t_word   r_value;
    t_addr   r_head;
    t_count  r_count;
    t_addr   r_idx;
    t_word   r_popped;
    t_status r_status;
    logic    r_out_valid;
    t_word   r_out_popped;
    t_status r_out_status;
    t_count  r_out_occ;

    t_addr   rd_addr;
    t_addr   idx_next;
    t_count  idx_plus1;

    assign idx_next  = r_idx + t_addr'(1);
    assign idx_plus1 = t_count'(r_idx) + t_count'(1);
    assign rd_addr   = slot_of(r_head, i_cmd.rd_next ? idx_next : r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_push) begin
            mem[slot_of(r_head, r_count[ADDR_W-1:0])] <= r_value;
        end else if (i_cmd.wr_shift) begin
            mem[slot_of(r_head, r_idx)] <= r_rd_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func  <= t_func'(i_func);
            r_value <= t_word'(i_value);
        end
        if (i_cmd.set_popped) begin
            r_popped <= r_rd_data;
        end else if (i_cmd.load_in) begin
            r_popped <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end else if (i_cmd.load_in) begin
            r_status <= ST_OK;
        end
        if (i_cmd.load_in) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_next;
        end
        if (i_cmd.load_out) begin
            r_out_popped <= r_popped;
            r_out_status <= r_status;
            r_out_occ    <= r_count;
        end
    end

    // queue pointers and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.head_inc) begin
                r_head <= slot_of(r_head, t_addr'(1));
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + t_count'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - t_count'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.func     = r_func;
        o_stat.full     = (r_count == t_count'(DEPTH));
        o_stat.empty    = (r_count == '0);
        o_stat.match    = (r_rd_data == r_value);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = (idx_plus1 >= r_count);
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_popped    = 32'(r_out_popped);
    assign o_status    = r_out_status;
    assign o_occupancy = 5'(r_out_occ);

endmodule

@@ rtl/core/fifo_with_remove_by_value.sv @@
// ----------------------------------------------------------------------------
// fifo_with_remove_by_value - bounded FIFO with push, pop and remove-by-value
// Usage:
//   Slave side takes one word per operation: s_axis_tuser selects push (0),
//   pop (1) or remove first matching value (2); s_axis_tdata carries the
//   value. Code 3 does nothing and reports ok.
//   Master side returns one word per operation: popped value, occupancy
//   after the operation in tdata, status in tuser (0 ok, 1 empty on pop,
//   2 full on push, 3 value not found).
// Sequencing: one operation at a time. After the accept, push, no-op or
//   an empty-queue pop/remove pass through the execute and response
//   steps; pop adds a data step; remove reads and compares queue
//   positions from the head until a match or the last word, then closes
//   up each word behind the match (one read and one write per word). A
//   new word is taken in the cycle after the result is loaded.
// Reset: synchronous, active low; the queue comes up empty with no result
//   pending. Stored words are not cleared.
// Stall: the result waits in the output register; the next operation is
//   accepted and worked on, and holds in its response step until the
//   previous result is taken.
// ----------------------------------------------------------------------------
module fifo_with_remove_by_value (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] popped_value, [36:32] occupancy, [39:37] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import fifo_rbv_pkg::*;

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [31:0] popped;
    logic [1:0]  status;
    logic [4:0]  occupancy;

    // sequencer: decides each step of the operation
    fifo_rbv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // storage, pointers and result register
    fifo_rbv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_popped    (popped),
        .o_status    (status),
        .o_occupancy (occupancy)
    );

    // pack the result word
    assign m_axis_tdata = {3'b000, occupancy, popped};
    assign m_axis_tuser = status;

endmodule

@@ rtl/core/fifo_rbv_chk.sv @@
// ----------------------------------------------------------------------------
// fifo_rbv_chk - port-level checks for the remove-by-value queue
// Watches the result channel for handshake hold and status consistency.
// ----------------------------------------------------------------------------
module fifo_rbv_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import fifo_rbv_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:32] <= 5'(DEPTH))
        else $error("occupancy above depth");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL |-> m_axis_tdata[36:32] == 5'(DEPTH))
        else $error("full status with queue not full");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY
            |-> m_axis_tdata[36:32] == 5'd0 && m_axis_tdata[31:0] == 32'd0)
        else $error("empty status with words held or value returned");

    a_popped_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31:0] != 32'd0 |-> m_axis_tuser == ST_OK)
        else $error("value returned with error status");

endmodule

bind fifo_with_remove_by_value fifo_rbv_chk u_fifo_rbv_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
